### src/lru_content_cache_unit_defines.svh
// Assertion macros used by the cache top level.
`ifndef LRU_CONTENT_CACHE_UNIT_DEFINES_SVH
`define LRU_CONTENT_CACHE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LCC_ASSERT(lbl, prop, msg)
`define LCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/lcc_pkg.sv
// Shared types and constants of the LRU content cache.
package lcc_pkg;

    localparam int KEY_W = 64;
    localparam int CAP_W = 5;
    localparam int CMD_W = 2;
    localparam int OUT_W = 72;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_PROBE  = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } t_state;

    // Per-cell control for one update cycle.
    typedef struct packed {
        logic shift;
        logic flush;
    } t_cell_ctrl;

endpackage

### src/lcc_cell.sv
// One cache cell: a key and its valid bit, compared in place and shifted from the left neighbor.
module lcc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lcc_pkg::KEY_W-1:0]    i_cmp_key,
    input  logic [lcc_pkg::KEY_W-1:0]    i_left_key,
    input  logic                         i_left_valid,
    input  lcc_pkg::t_cell_ctrl          i_ctrl,
    output logic [lcc_pkg::KEY_W-1:0]    o_key,
    output logic                         o_valid,
    output logic                         o_match
);

    logic [lcc_pkg::KEY_W-1:0] r_key;
    logic                      r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.flush) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key <= i_left_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_cmp_key);

endmodule

### src/lru_content_cache_unit.sv
// Top level of the LRU content cache: cell row, control sequencer and output register.
//
// Requests enter on the s_axis channel: tuser carries the command (lookup, store, probe,
// flush) and tdata the 64-bit key. Each item yields exactly one result on the m_axis
// channel with hit, eviction flag, evicted key and the full flag. The user sets the cache
// capacity via i_cfg_wr_en / i_cfg_wr_data only while idle; not enforced by the block.
//
// The result is loaded into the output register at the end of the update state, and
// no new item is accepted before that. In the accept cycle every cell compares its
// key against the request and the match vector is registered; in the update state a
// promote or a store miss shifts the row of cells toward the tail up to the hit or
// insert position while the head cell loads the request key, and a flush clears every cell.
//
// Reset empties the cache (all cells invalid, occupancy zero) and sets the
// capacity to 16. When the receiver stalls, the result is held in the output
// register and no further item is accepted until it has been taken.
`include "lru_content_cache_unit_defines.svh"

module lru_content_cache_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lcc_pkg::KEY_W-1:0]     s_axis_tdata,   // [63:0] key
    input  logic [lcc_pkg::CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] hit, [1] evicted_valid, [65:2] evicted_key, [66] is_full, [71:67] zero
    output logic [lcc_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [lcc_pkg::CAP_W-1:0]     i_cfg_wr_data
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lcc_pkg::CAP_W) ? OCC_W : lcc_pkg::CAP_W;

    lcc_pkg::t_state              r_state;
    lcc_pkg::t_cmd                r_cmd;
    logic [lcc_pkg::KEY_W-1:0]    r_key;
    logic [ENTRIES-1:0]           r_match;
    logic [lcc_pkg::KEY_W-1:0]    r_last_key;
    logic [OCC_W-1:0]             r_occ;
    logic [OCC_W-1:0]             n_occ;
    logic [lcc_pkg::CAP_W-1:0]    r_cap;

    logic                         r_out_valid;
    logic                         r_hit;
    logic                         r_ev_valid;
    logic [lcc_pkg::KEY_W-1:0]    r_ev_key;
    logic                         r_full;

    logic [lcc_pkg::KEY_W-1:0]    w_cell_key   [ENTRIES];
    logic [ENTRIES-1:0]           w_cell_valid;
    logic [ENTRIES-1:0]           w_cell_match;
    lcc_pkg::t_cell_ctrl          w_ctrl       [ENTRIES];
    logic [lcc_pkg::KEY_W-1:0]    w_last_key;

    logic                         w_accept;
    logic                         w_update;
    logic                         w_hit;
    logic                         w_miss_store;
    logic                         w_evict;
    logic [OCC_W-1:0]             w_eff_cap;
    logic [OCC_W-1:0]             w_limit;
    logic [CMP_W-1:0]             w_cap_ext;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_update = (r_state == lcc_pkg::ST_UPDATE);
    assign s_axis_tready = (r_state == lcc_pkg::ST_IDLE) && (!r_out_valid || m_axis_tready);

    // Capacity zero counts as one; anything above the cell count saturates.
    assign w_cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = OCC_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_eff_cap = OCC_W'(ENTRIES);
        end else begin
            w_eff_cap = OCC_W'(w_cap_ext);
        end
    end

    assign w_hit        = (|r_match) && (r_cmd != lcc_pkg::CMD_FLUSH);
    assign w_miss_store = !w_hit && (r_cmd == lcc_pkg::CMD_STORE);
    assign w_evict      = w_miss_store && (r_occ >= w_eff_cap) && (r_occ != '0);
    // Last cell that moves on an insert: the tail when evicting, else the first free cell.
    assign w_limit      = w_evict ? (r_occ - OCC_W'(1)) : r_occ;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic [lcc_pkg::KEY_W-1:0] w_left_key;
            logic                      w_left_valid;
            logic                      w_promote;

            if (gi == 0) begin : g_head
                assign w_left_key   = r_key;
                assign w_left_valid = 1'b1;
            end else begin : g_body
                assign w_left_key   = w_cell_key[gi-1];
                assign w_left_valid = w_cell_valid[gi-1];
            end

            // A cell moves on a promote when the hit lies at or beyond it.
            assign w_promote = |(r_match >> gi);

            always_comb begin
                w_ctrl[gi].flush = w_update && (r_cmd == lcc_pkg::CMD_FLUSH);
                w_ctrl[gi].shift = 1'b0;
                if (w_update) begin
                    if (w_hit && (r_cmd != lcc_pkg::CMD_PROBE)) begin
                        w_ctrl[gi].shift = w_promote;
                    end else if (w_miss_store) begin
                        w_ctrl[gi].shift = (OCC_W'(gi) <= w_limit);
                    end
                end
            end

            lcc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmp_key    (s_axis_tdata),
                .i_left_key   (w_left_key),
                .i_left_valid (w_left_valid),
                .i_ctrl       (w_ctrl[gi]),
                .o_key        (w_cell_key[gi]),
                .o_valid      (w_cell_valid[gi]),
                .o_match      (w_cell_match[gi])
            );
        end
    endgenerate

    // Key of the least recent cell, picked while the request is accepted.
    always_comb begin
        w_last_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (OCC_W'(i + 1) == r_occ) begin
                w_last_key = w_last_key | w_cell_key[i];
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (w_update) begin
            if (r_cmd == lcc_pkg::CMD_FLUSH) begin
                n_occ = '0;
            end else if (w_miss_store && !w_evict) begin
                n_occ = r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcc_pkg::ST_IDLE;
            r_occ   <= '0;
            r_cap   <= lcc_pkg::CAP_RESET;
        end else begin
            r_occ <= n_occ;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            unique case (r_state)
                lcc_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= lcc_pkg::ST_UPDATE;
                    end
                end
                lcc_pkg::ST_UPDATE: begin
                    r_state <= lcc_pkg::ST_IDLE;
                end
                default: begin
                    r_state <= lcc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= lcc_pkg::t_cmd'(s_axis_tuser);
            r_key      <= s_axis_tdata;
            r_match    <= w_cell_match;
            r_last_key <= w_last_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_hit      <= w_hit;
            r_ev_valid <= w_evict;
            r_ev_key   <= w_evict ? r_last_key : '0;
            r_full     <= (n_occ >= w_eff_cap);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_full, r_ev_key, r_ev_valid, r_hit};

    `LCC_ASSERT(a_valid_count, ($countones(w_cell_valid) == int'(r_occ)), "valid cells differ from occupancy")
    `LCC_ASSERT(a_match_unique, (w_update |-> $onehot0(r_match)), "key held in more than one cell")
    `LCC_ASSERT(a_evict_full, ((r_out_valid && r_ev_valid) |-> (r_full && !r_hit)), "eviction without full cache")
    `LCC_ASSERT(a_accept_update, (w_accept |=> w_update), "accepted item not processed")
    `LCC_ASSERT_ALWAYS(a_occ_bound, (!i_rst_n || (int'(r_occ) <= ENTRIES)), "occupancy beyond cell count")

endmodule

### bench/tb_top.sv
// Self-checking LRU content cache bench: directed and random traffic against a recency-list model.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 16;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    // Layout of m_axis_tdata, lowest bit last.
    typedef struct packed {
        logic [lcc_pkg::OUT_W-lcc_pkg::KEY_W-4:0] pad;
        logic                                     full;
        logic [lcc_pkg::KEY_W-1:0]                evicted_key;
        logic                                     evicted_valid;
        logic                                     hit;
    } t_cache_result;

    typedef struct {
        lcc_pkg::t_cmd             cmd;
        logic [lcc_pkg::KEY_W-1:0] key;
        int unsigned               gap;
    } t_cache_req;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [lcc_pkg::KEY_W-1:0]     s_axis_tdata = '0;     // [63:0] key
    logic [lcc_pkg::CMD_W-1:0]     s_axis_tuser = '0;     // [1:0] cmd
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [0] hit, [1] evicted_valid, [65:2] evicted_key, [66] is_full, [71:67] zero
    logic [lcc_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                          i_cfg_wr_en = 1'b0;
    logic [lcc_pkg::CAP_W-1:0]     i_cfg_wr_data = '0;

    lru_content_cache_unit #(
        .ENTRIES(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the cache contents: slot 0 is the most recent key.
    logic [lcc_pkg::KEY_W-1:0] recency_keys [DEPTH];
    int                        fill_level = 0;
    logic [lcc_pkg::CAP_W-1:0] capacity_reg = lcc_pkg::CAP_RESET;

    t_cache_req       pending_reqs [$];
    t_cache_result    expected_results [$];
    int unsigned      n_queued = 0;
    int unsigned      n_sent = 0;
    int unsigned      n_received = 0;
    int unsigned      n_hits = 0;
    int unsigned      n_evictions = 0;
    int unsigned      n_cap_writes = 0;
    int unsigned      mismatches = 0;

    int unsigned      send_wait = 0;
    int unsigned      recv_wait = 0;
    int               recv_mode = 0;
    int unsigned      hold_asks = 0;
    int unsigned      holds_done = 0;
    int unsigned      hold_left = 0;
    int unsigned      quiet_cycles = 0;
    t_cache_req       next_req;
    t_cache_result    want;
    t_cache_result    got;

    function automatic int capacity_limit();
        if (capacity_reg == '0) return 1;
        if (int'(capacity_reg) > DEPTH) return DEPTH;
        return int'(capacity_reg);
    endfunction

    function automatic int unsigned draw_gap(input int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 19);
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
    endfunction

    function automatic logic [lcc_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Applies one request to the model and queues the result it must produce.
    task automatic cache_access(input lcc_pkg::t_cmd op, input logic [lcc_pkg::KEY_W-1:0] k);
        t_cache_result             r;
        int                        pos;
        int                        lim;
        logic [lcc_pkg::KEY_W-1:0] moved;
        r = '0;
        lim = capacity_limit();
        pos = -1;
        if (op == lcc_pkg::CMD_FLUSH) begin
            fill_level = 0;
        end else begin
            for (int i = 0; i < fill_level; i++) begin
                if (pos < 0 && recency_keys[i] == k) pos = i;
            end
            if (pos >= 0) begin
                r.hit = 1'b1;
                n_hits++;
                if (op != lcc_pkg::CMD_PROBE) begin
                    moved = recency_keys[pos];
                    for (int i = pos; i > 0; i--) recency_keys[i] = recency_keys[i-1];
                    recency_keys[0] = moved;
                end
            end else if (op == lcc_pkg::CMD_STORE) begin
                // At or above capacity the tail drops out and occupancy holds,
                // even when the capacity was lowered below the current fill.
                if (fill_level >= lim) begin
                    r.evicted_valid = 1'b1;
                    r.evicted_key = recency_keys[fill_level-1];
                    n_evictions++;
                    for (int i = fill_level - 1; i > 0; i--) recency_keys[i] = recency_keys[i-1];
                end else begin
                    for (int i = fill_level; i > 0; i--) recency_keys[i] = recency_keys[i-1];
                    fill_level++;
                end
                recency_keys[0] = k;
            end
        end
        r.full = (fill_level >= lim);
        expected_results.push_back(r);
    endtask

    task automatic push_req(input lcc_pkg::t_cmd op, input logic [lcc_pkg::KEY_W-1:0] k,
                            input int unsigned g);
        t_cache_req it;
        it.cmd = op;
        it.key = k;
        it.gap = g;
        pending_reqs.push_back(it);
        n_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_sent != n_queued || expected_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [lcc_pkg::CAP_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        capacity_reg = v;
        n_cap_writes++;
    endtask

    // Keys come mostly from a pool a little larger than the capacity, so that
    // hits, misses and evictions all occur; the rest are fresh or one bit off.
    task automatic queue_random_phase(input int n, input int gap_mode);
        logic [lcc_pkg::KEY_W-1:0] pool [$];
        int                        pool_sz;
        int                        roll;
        lcc_pkg::t_cmd             op;
        logic [lcc_pkg::KEY_W-1:0] k;
        pool_sz = capacity_limit() + $urandom_range(1, 6);
        for (int i = 0; i < pool_sz; i++) pool.push_back(rand_key());
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) op = lcc_pkg::CMD_FLUSH;
            else if (roll < 48) op = lcc_pkg::CMD_STORE;
            else if (roll < 75) op = lcc_pkg::CMD_LOOKUP;
            else op = lcc_pkg::CMD_PROBE;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                k = rand_key();
            end else if (roll < 13) begin
                k = pool[$urandom_range(0, pool_sz - 1)] ^ (64'd1 << $urandom_range(0, 63));
            end else begin
                k = pool[$urandom_range(0, pool_sz - 1)];
            end
            push_req(op, k, draw_gap(gap_mode));
        end
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                cache_access(lcc_pkg::t_cmd'(s_axis_tuser), s_axis_tdata);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    s_axis_tdata <= next_req.key;
                    s_axis_tuser <= next_req.cmd;
                    s_axis_tvalid <= 1'b1;
                    send_wait = next_req.gap;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_cache_result'(m_axis_tdata);
                n_received++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result %h arrived with none expected", m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
                        got.evicted_key !== want.evicted_key || got.full !== want.full ||
                        got.pad !== want.pad) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR: result %0d exp hit=%b ev=%b key=%h full=%b pad=%h",
                                     n_received, want.hit, want.evicted_valid,
                                     want.evicted_key, want.full, want.pad,
                                     "\n       got hit=%b ev=%b key=%h full=%b pad=%h",
                                     got.hit, got.evicted_valid, got.evicted_key,
                                     got.full, got.pad);
                    end
                end
                recv_wait = draw_gap(recv_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_asks != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                    $display("tb_top failed");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [lcc_pkg::CAP_W-1:0] cap_plan [12];
        logic [lcc_pkg::KEY_W-1:0] ka;
        logic [lcc_pkg::KEY_W-1:0] kb;
        logic [lcc_pkg::KEY_W-1:0] kc;
        cap_plan = '{5'd16, 5'd4, 5'd31, 5'd1, 5'd0, 5'd17, 5'd16, 5'd8, 5'd2, 5'd12, 5'd5, 5'd16};
        ka = rand_key();
        kb = rand_key();
        kc = rand_key();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity: misses on an empty cache, key extremes, promote and flush.
        recv_mode = 1;
        push_req(lcc_pkg::CMD_LOOKUP, '0, draw_gap(1));
        push_req(lcc_pkg::CMD_PROBE, '1, draw_gap(1));
        push_req(lcc_pkg::CMD_STORE, '0, draw_gap(1));
        push_req(lcc_pkg::CMD_STORE, '1, draw_gap(1));
        push_req(lcc_pkg::CMD_LOOKUP, '0, draw_gap(1));
        push_req(lcc_pkg::CMD_PROBE, '1, draw_gap(1));
        push_req(lcc_pkg::CMD_FLUSH, '1, draw_gap(1));
        push_req(lcc_pkg::CMD_LOOKUP, '1, draw_gap(1));
        wait_idle();

        // Capacity two: a probe must not save a key from eviction, and a store
        // of a present key only promotes it.
        write_capacity(5'd2);
        push_req(lcc_pkg::CMD_STORE, ka, 0);
        push_req(lcc_pkg::CMD_STORE, kb, 0);
        push_req(lcc_pkg::CMD_PROBE, ka, 0);
        push_req(lcc_pkg::CMD_STORE, kc, 0);
        push_req(lcc_pkg::CMD_STORE, kb, 0);
        push_req(lcc_pkg::CMD_STORE, ka, 0);
        wait_idle();

        // Capacity zero acts as one, and the cache is now above it.
        write_capacity(5'd0);
        push_req(lcc_pkg::CMD_STORE, kc, draw_gap(2));
        push_req(lcc_pkg::CMD_STORE, ~kc, draw_gap(2));
        push_req(lcc_pkg::CMD_LOOKUP, ~kc, draw_gap(2));
        wait_idle();
        write_capacity(5'd31);
        push_req(lcc_pkg::CMD_STORE, ka ^ kb, 0);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            write_capacity(cap_plan[p]);
            recv_mode = (p + 1) % 3;
            if (p == 3) begin
                // Receiver stops for a long stretch while requests keep coming.
                queue_random_phase(ITEMS_PER_PHASE, 0);
                hold_asks++;
            end else begin
                queue_random_phase(ITEMS_PER_PHASE, p % 3);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("Ran %0d requests through %0d capacity writes: %0d hits, %0d evictions.",
                 n_sent, n_cap_writes, n_hits, n_evictions);
        $display("Results checked: %0d, mismatches: %0d", n_received, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/lcc_pkg.sv
src/lcc_cell.sv
src/lru_content_cache_unit.sv
bench/tb_top.sv
